>>> src/psa_pkg.sv
// psa_pkg: shared types, constants and encoders for the paged slot allocator
// no dependencies; imported by every module of the block
`default_nettype none

package psa_pkg;

  localparam int SLOTS_PER_ROW = 8;
  localparam int MAX_ROWS      = 16;
  localparam int SLOT_W        = 7;
  localparam int CFG_W         = 5;
  localparam int ROW_W         = $clog2(MAX_ROWS);
  localparam int POS_W         = $clog2(SLOTS_PER_ROW);
  localparam int REM_W         = $clog2(SLOTS_PER_ROW + 1);
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_NO_PAGE  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEL,
    BK_WR
  } back_state_t;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot_id;
    logic              page_ok;
    logic              row_oob;
  } q_item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] granted_slot;
    logic              page_taken;
    logic              page_released;
    logic [ROW_W-1:0]  row_touched;
  } res_t;

  function automatic logic [ROW_W-1:0] first_set_row(input logic [MAX_ROWS-1:0] v);
    logic [ROW_W-1:0] idx;
    idx = '0;
    for (int i = MAX_ROWS - 1; i >= 0; i--) begin
      if (v[i]) idx = ROW_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [POS_W-1:0] first_zero_pos(input logic [SLOTS_PER_ROW-1:0] v);
    logic [POS_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS_PER_ROW - 1; i >= 0; i--) begin
      if (!v[i]) idx = POS_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> src/psa_front.sv
// psa_front: row-count register and request classification
// depends on psa_pkg; feeds classified requests to psa_queue
`default_nettype none

module psa_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [psa_pkg::CFG_W-1:0]     cfg_active_rows,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           in_cmd,
  input  wire  [psa_pkg::SLOT_W-1:0]    in_slot_id,
  input  wire                           in_page_ok,
  input  wire                           q_full,
  output logic                          q_push,
  output psa_pkg::q_item_t              q_item,
  output logic [psa_pkg::CFG_W-1:0]     rows_in_use
);
  import psa_pkg::*;

  logic [CFG_W-1:0] active_rows_r;
  logic [ROW_W-1:0] in_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_rows_r <= CFG_W'(MAX_ROWS);
    end else if (cfg_valid && cfg_ready) begin
      active_rows_r <= cfg_active_rows;
    end
  end

  assign cfg_ready   = 1'b1;
  assign rows_in_use = (active_rows_r > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : active_rows_r;

  assign in_row   = in_slot_id[SLOT_W-1:POS_W];
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.cmd     = in_cmd;
    q_item.slot_id = in_slot_id;
    q_item.page_ok = in_page_ok;
    q_item.row_oob = (CFG_W'(in_row) >= rows_in_use);
  end

endmodule

`default_nettype wire

>>> src/psa_queue.sv
// psa_queue: short request queue between front and back
// depends on psa_pkg for the entry type and depth
`default_nettype none

module psa_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  psa_pkg::q_item_t      push_item,
  output logic                  full,
  input  wire                   pop,
  output logic                  q_valid,
  output psa_pkg::q_item_t      head
);
  import psa_pkg::*;

  q_item_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/psa_back.sv
// psa_back: row selection, slot read-modify-write and result register
// depends on psa_pkg; takes requests from psa_queue
`default_nettype none

module psa_back (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        q_valid,
  input  psa_pkg::q_item_t           head,
  output logic                       pop,
  input  wire  [psa_pkg::CFG_W-1:0]  rows_in_use,
  output logic                       out_valid,
  input  wire                        out_stall,
  output psa_pkg::res_t              res
);
  import psa_pkg::*;

  back_state_t state_r, state_nxt;

  logic [SLOTS_PER_ROW-1:0] row_used_r   [MAX_ROWS];
  logic                     row_backed_r [MAX_ROWS];
  logic [REM_W-1:0]         row_rem_r    [MAX_ROWS];

  q_item_t          item_r;
  logic             sel_avail_r;
  logic [ROW_W-1:0] avail_row_r;
  logic             sel_unb_r;
  logic [ROW_W-1:0] unb_row_r;
  logic             out_valid_r;
  res_t             res_r;

  logic                sel_load;
  logic                commit;
  logic [MAX_ROWS-1:0] avail_vec;
  logic [MAX_ROWS-1:0] unb_vec;

  logic [ROW_W-1:0]         item_row;
  logic [POS_W-1:0]         item_pos;
  logic [ROW_W-1:0]         rd_row;
  logic [SLOTS_PER_ROW-1:0] rd_used;
  logic                     rd_backed;
  logic [REM_W-1:0]         rd_rem;
  logic [POS_W-1:0]         zero_pos;
  logic [REM_W-1:0]         rem_inc;

  logic                     wr_en;
  logic [SLOTS_PER_ROW-1:0] wr_used;
  logic                     wr_backed;
  logic [REM_W-1:0]         wr_rem;
  res_t                     res_nxt;

  // state machine
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_SEL;
      BK_SEL:  state_nxt = BK_WR;
      BK_WR: begin
        if (commit) state_nxt = q_valid ? BK_SEL : BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    sel_load = 1'b0;
    commit   = 1'b0;
    pop      = 1'b0;
    unique case (state_r)
      BK_IDLE: pop = q_valid;
      BK_SEL:  sel_load = 1'b1;
      BK_WR: begin
        commit = !out_valid_r || !out_stall;
        pop    = commit && q_valid;
      end
      default: ;
    endcase
  end

  // row flags
  always_comb begin
    for (int r = 0; r < MAX_ROWS; r++) begin
      avail_vec[r] = (CFG_W'(r) < rows_in_use) && row_backed_r[r] && (row_rem_r[r] != '0);
      unb_vec[r]   = (CFG_W'(r) < rows_in_use) && !row_backed_r[r];
    end
  end

  // one row read port
  assign item_row  = item_r.slot_id[SLOT_W-1:POS_W];
  assign item_pos  = item_r.slot_id[POS_W-1:0];
  assign rd_row    = (item_r.cmd == CMD_FREE) ? item_row :
                     (sel_avail_r ? avail_row_r : unb_row_r);
  assign rd_used   = row_used_r[rd_row];
  assign rd_backed = row_backed_r[rd_row];
  assign rd_rem    = row_rem_r[rd_row];
  assign zero_pos  = first_zero_pos(rd_used);
  assign rem_inc   = rd_rem + 1'b1;

  always_comb begin
    wr_en     = 1'b0;
    wr_used   = rd_used;
    wr_backed = rd_backed;
    wr_rem    = rd_rem;
    res_nxt   = '{status: ST_OK, granted_slot: '0, page_taken: 1'b0,
                  page_released: 1'b0, row_touched: '0};
    if (item_r.cmd == CMD_FREE) begin
      if (item_r.row_oob || !rd_backed || !rd_used[item_pos]) begin
        res_nxt.status = ST_BAD_FREE;
      end else begin
        wr_en                = 1'b1;
        res_nxt.row_touched  = rd_row;
        if (rem_inc >= REM_W'(SLOTS_PER_ROW)) begin
          wr_used               = '0;
          wr_backed             = 1'b0;
          wr_rem                = '0;
          res_nxt.page_released = 1'b1;
        end else begin
          wr_used[item_pos] = 1'b0;
          wr_rem            = rem_inc;
        end
      end
    end else begin
      priority if (sel_avail_r) begin
        wr_en                = 1'b1;
        wr_used[zero_pos]    = 1'b1;
        wr_rem               = rd_rem - 1'b1;
        res_nxt.granted_slot = {rd_row, zero_pos};
        res_nxt.row_touched  = rd_row;
      end else if (!sel_unb_r) begin
        res_nxt.status = ST_NO_SLOT;
      end else if (!item_r.page_ok) begin
        res_nxt.status = ST_NO_PAGE;
      end else begin
        wr_en                = 1'b1;
        wr_used              = SLOTS_PER_ROW'(1);
        wr_backed            = 1'b1;
        wr_rem               = REM_W'(SLOTS_PER_ROW - 1);
        res_nxt.granted_slot = {rd_row, POS_W'(0)};
        res_nxt.page_taken   = 1'b1;
        res_nxt.row_touched  = rd_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item_r <= head;
    if (sel_load) begin
      sel_avail_r <= (avail_vec != '0);
      avail_row_r <= first_set_row(avail_vec);
      sel_unb_r   <= (unb_vec != '0);
      unb_row_r   <= first_set_row(unb_vec);
    end
    if (commit) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      for (int r = 0; r < MAX_ROWS; r++) begin
        row_used_r[r]   <= '0;
        row_backed_r[r] <= 1'b0;
        row_rem_r[r]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= commit || (out_valid_r && out_stall);
      if (commit && wr_en) begin
        row_used_r[rd_row]   <= wr_used;
        row_backed_r[rd_row] <= wr_backed;
        row_rem_r[rd_row]    <= wr_rem;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  a_wr_after_sel: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_WR && $past(state_r) != BK_WR |-> $past(state_r) == BK_SEL)
    else $error("write step not preceded by row select");

  a_commit_only_wr: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> state_r == BK_WR)
    else $error("result committed outside write step");

  a_taken_is_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    commit && res_nxt.page_taken |-> item_r.cmd == CMD_ALLOC && res_nxt.status == ST_OK)
    else $error("page taken by a request that is not a good allocation");

  a_released_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit && res_nxt.page_released |=> !row_backed_r[$past(rd_row)])
    else $error("released row still backed");

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_row_chk
    a_unbacked_clear: assert property (@(posedge clk) disable iff (!rst_n)
      !row_backed_r[g] |-> row_rem_r[g] == '0 && row_used_r[g] == '0)
      else $error("row without page holds slots");
  end

endmodule

`default_nettype wire

>>> src/paged_slot_allocator.sv
// paged_slot_allocator: top level of the paged slot allocator
// depends on psa_pkg, psa_front, psa_queue and psa_back
//
// usage:
//   in_*  channel: one request beat (cmd, slot_id, page_ok), taken when
//                  in_valid is high and in_stall is low
//   out_* channel: one result beat per request, in request order, taken
//                  when out_valid is high and out_stall is low
//   cfg_* channel: writes active_rows, taken when cfg_valid and cfg_ready
//                  are high; cfg_ready is always high, write only when idle
// a request goes from the queue to the back end's select and write steps
// the back end takes one request at a time: its row select step is
//   followed by its slot read-modify-write step on the row store
// a two-beat queue sits between front and back, so requests are still
//   accepted while a result waits in the output register, until it fills
// reset: all rows unbacked, all slots free, active_rows = 16, no results
// when out_stall is high the result holds; the back end waits with the
//   next request in its write step and the queue fills, then in_stall rises
`default_nettype none

module paged_slot_allocator (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [psa_pkg::CFG_W-1:0]   cfg_active_rows,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire                         in_cmd,
  input  wire  [psa_pkg::SLOT_W-1:0]  in_slot_id,
  input  wire                         in_page_ok,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [1:0]                  out_status,
  output logic [psa_pkg::SLOT_W-1:0]  out_granted_slot,
  output logic                        out_page_taken,
  output logic                        out_page_released,
  output logic [psa_pkg::ROW_W-1:0]   out_row_touched
);
  import psa_pkg::*;

  logic             q_full;
  logic             q_push;
  q_item_t          q_item;
  logic             q_valid;
  q_item_t          q_head;
  logic             q_pop;
  logic [CFG_W-1:0] rows_in_use;
  res_t             res;

  psa_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_active_rows (cfg_active_rows),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_slot_id      (in_slot_id),
    .in_page_ok      (in_page_ok),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_item),
    .rows_in_use     (rows_in_use)
  );

  psa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .head      (q_head)
  );

  psa_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .head        (q_head),
    .pop         (q_pop),
    .rows_in_use (rows_in_use),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  assign out_status        = res.status;
  assign out_granted_slot  = res.granted_slot;
  assign out_page_taken    = res.page_taken;
  assign out_page_released = res.page_released;
  assign out_row_touched   = res.row_touched;

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// testbench for paged_slot_allocator: directed and random allocate/free traffic,
// each result beat checked against an in-bench model of the row and slot stores
// depends on psa_pkg and the paged_slot_allocator rtl

module testbench;
  import psa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 120;
  localparam int TOTAL_SLOTS = SLOTS_PER_ROW * MAX_ROWS;

  typedef struct {
    logic              cmd;
    logic [SLOT_W-1:0] slot_id;
    logic              page_ok;
    logic              live;
  } request_t;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] granted;
    logic              taken;
    logic              released;
    logic [ROW_W-1:0]  row;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_active_rows = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd = CMD_ALLOC;
  logic [SLOT_W-1:0] in_slot_id = '0;
  logic              in_page_ok = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [SLOT_W-1:0] out_granted_slot;
  logic              out_page_taken;
  logic              out_page_released;
  logic [ROW_W-1:0]  out_row_touched;

  // allocator model state
  logic             slot_used [TOTAL_SLOTS];
  logic             row_backed [MAX_ROWS];
  logic [REM_W-1:0] row_left [MAX_ROWS];
  logic [CFG_W-1:0] rows_cfg;

  request_t    pending_q[$];
  outcome_t    outcome_q[$];
  request_t    cur;
  int unsigned queued_n = 0;
  int unsigned accepted_n = 0;
  int unsigned cfg_writes = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  logic        beat_taken = 1'b0;
  logic        hold_kick = 1'b0;

  paged_slot_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_active_rows   (cfg_active_rows),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_slot_id        (in_slot_id),
    .in_page_ok        (in_page_ok),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_slot  (out_granted_slot),
    .out_page_taken    (out_page_taken),
    .out_page_released (out_page_released),
    .out_row_touched   (out_row_touched)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rows_live();
    return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int       n;
    int       spare;
    int       row;
    int       s;
    o.status   = ST_OK;
    o.granted  = '0;
    o.taken    = 1'b0;
    o.released = 1'b0;
    o.row      = '0;
    n = rows_live();
    spare = -1;
    if (r.cmd == CMD_ALLOC) begin
      for (int rw = 0; rw < n; rw++) begin
        if (!row_backed[rw]) begin
          if (spare < 0) spare = rw;
        end else if (row_left[rw] != 0) begin
          for (int p = 0; p < SLOTS_PER_ROW; p++) begin
            s = rw * SLOTS_PER_ROW + p;
            if (!slot_used[s]) begin
              slot_used[s] = 1'b1;
              row_left[rw] = row_left[rw] - 1'b1;
              o.granted = SLOT_W'(s);
              o.row = ROW_W'(rw);
              return o;
            end
          end
        end
      end
      if (spare < 0) begin
        o.status = ST_NO_SLOT;
      end else if (!r.page_ok) begin
        o.status = ST_NO_PAGE;
      end else begin
        for (int p = 1; p < SLOTS_PER_ROW; p++) slot_used[spare * SLOTS_PER_ROW + p] = 1'b0;
        slot_used[spare * SLOTS_PER_ROW] = 1'b1;
        row_backed[spare] = 1'b1;
        row_left[spare] = REM_W'(SLOTS_PER_ROW - 1);
        o.granted = SLOT_W'(spare * SLOTS_PER_ROW);
        o.taken = 1'b1;
        o.row = ROW_W'(spare);
      end
    end else begin
      row = int'(r.slot_id) / SLOTS_PER_ROW;
      s = int'(r.slot_id);
      if (row >= n || !row_backed[row] || !slot_used[s]) begin
        o.status = ST_BAD_FREE;
      end else begin
        slot_used[s] = 1'b0;
        row_left[row] = row_left[row] + 1'b1;
        o.row = ROW_W'(row);
        if (row_left[row] >= SLOTS_PER_ROW) begin
          row_backed[row] = 1'b0;
          row_left[row] = '0;
          for (int p = 0; p < SLOTS_PER_ROW; p++) slot_used[row * SLOTS_PER_ROW + p] = 1'b0;
          o.released = 1'b1;
        end
      end
    end
    return o;
  endfunction

  // random slot currently in use within the active rows, or the fallback if none is
  function automatic logic [SLOT_W-1:0] pick_live_slot(logic [SLOT_W-1:0] fallback);
    int live[$];
    for (int s = 0; s < rows_live() * SLOTS_PER_ROW; s++) begin
      if (slot_used[s]) live.push_back(s);
    end
    if (live.size() == 0) return fallback;
    return SLOT_W'(live[$urandom_range(live.size() - 1)]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  task automatic push_req(logic cmd, int slot, logic page_ok, logic live);
    request_t r;
    r.cmd = cmd;
    r.slot_id = SLOT_W'(slot);
    r.page_ok = page_ok;
    r.live = live;
    pending_q.push_back(r);
    queued_n++;
  endtask

  task automatic push_random(int unsigned count);
    int unsigned left;
    int unsigned burst;
    int unsigned bias;
    logic        cmd;
    left = count;
    while (left != 0) begin
      bias = $urandom_range(95, 10);
      burst = $urandom_range(60, 20);
      if (burst > left) burst = left;
      repeat (burst) begin
        cmd = ($urandom_range(99) < bias) ? CMD_ALLOC : CMD_FREE;
        push_req(cmd, $urandom_range(127), $urandom_range(99) < 88, $urandom_range(99) < 85);
      end
      left -= burst;
    end
  endtask

  task automatic drain();
    while (accepted_n != queued_n || outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_rows(logic [CFG_W-1:0] v);
    int unsigned seen;
    @(negedge clk);
    seen = cfg_writes;
    cfg_active_rows <= v;
    cfg_valid <= 1'b1;
    while (cfg_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic kick_hold();
    @(negedge clk);
    hold_kick <= 1'b1;
    @(negedge clk);
    hold_kick <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur = pending_q.pop_front();
        if (cur.cmd == CMD_FREE && cur.live) cur.slot_id = pick_live_slot(cur.slot_id);
        in_valid   <= 1'b1;
        in_cmd     <= cur.cmd;
        in_slot_id <= cur.slot_id;
        in_page_ok <= cur.page_ok;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor: config and request beats update the model, result beats are checked
  always @(posedge clk) begin
    request_t r;
    outcome_t want;
    beat_taken = 1'b0;
    cycles++;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        rows_cfg = cfg_active_rows;
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        r.cmd = in_cmd;
        r.slot_id = in_slot_id;
        r.page_ok = in_page_ok;
        r.live = 1'b0;
        outcome_q.push_back(apply_request(r));
        accepted_n++;
        beat_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, status", out_status, 0);
        end else begin
          want = outcome_q.pop_front();
          if (out_status != want.status)
            report_mismatch("status", out_status, want.status);
          if (out_granted_slot != want.granted)
            report_mismatch("granted_slot", out_granted_slot, want.granted);
          if (out_page_taken != want.taken)
            report_mismatch("page_taken", out_page_taken, want.taken);
          if (out_page_released != want.released)
            report_mismatch("page_released", out_page_released, want.released);
          if (out_row_touched != want.row)
            report_mismatch("row_touched", out_row_touched, want.row);
        end
      end
    end
  end

  initial begin
    wait (cycles > CYCLE_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    for (int s = 0; s < TOTAL_SLOTS; s++) slot_used[s] = 1'b0;
    for (int rw = 0; rw < MAX_ROWS; rw++) begin
      row_backed[rw] = 1'b0;
      row_left[rw] = '0;
    end
    rows_cfg = CFG_W'(16);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 46;

    // one row: page refusal, fill, full, bad frees, refill, release
    write_rows(CFG_W'(1));
    push_req(CMD_ALLOC, 127, 1'b0, 1'b0);
    push_req(CMD_ALLOC, 0, 1'b1, 1'b0);
    repeat (7) push_req(CMD_ALLOC, 0, 1'b0, 1'b0);
    push_req(CMD_ALLOC, 0, 1'b1, 1'b0);
    push_req(CMD_FREE, 3, 1'b0, 1'b0);
    push_req(CMD_FREE, 3, 1'b1, 1'b0);
    push_req(CMD_FREE, 8, 1'b0, 1'b0);
    push_req(CMD_FREE, 127, 1'b1, 1'b0);
    push_req(CMD_ALLOC, 85, 1'b0, 1'b0);
    for (int s = 0; s < SLOTS_PER_ROW; s++) push_req(CMD_FREE, s, 1'b0, 1'b0);
    push_req(CMD_FREE, 0, 1'b0, 1'b0);
    drain();

    write_rows(CFG_W'(16));
    push_random(700);
    kick_hold();
    drain();

    send_idle_pct = 46;
    recv_idle_pct = 15;
    write_rows(CFG_W'(3));
    push_random(400);
    drain();

    write_rows(CFG_W'(31));
    push_random(300);
    kick_hold();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_rows(CFG_W'(0));
    push_random(40);
    drain();

    write_rows(CFG_W'(7));
    push_random(440);
    drain();

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
